// File: rtl/core/itse_pkg.sv
package itse_pkg;

   localparam int OP_STACK_DEPTH_DEF  = 16;
   localparam int NUM_STACK_DEPTH_DEF = 16;
   localparam int FRAC_BITS_DEF       = 16;

   typedef enum logic [2:0] {
      TK_ADD   = 3'd0,
      TK_SUB   = 3'd1,
      TK_MUL   = 3'd2,
      TK_DIV   = 3'd3,
      TK_OPEN  = 3'd4,
      TK_CLOSE = 3'd5,
      TK_END   = 3'd6,
      TK_OTHER = 3'd7
   } tok_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_SYNTAX   = 3'd1,
      ST_DIVZERO  = 3'd2,
      ST_UNPAIR   = 3'd3,
      ST_BADOP    = 3'd4,
      ST_OVERFLOW = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_TOP,
      S_POPB,
      S_POPA,
      S_EXEC,
      S_WAIT,
      S_PUSHR,
      S_FINAL,
      S_ANS,
      S_OUT
   } state_type;

   typedef struct packed {
      logic        command;
      logic [30:0] number_value;
      logic [2:0]  operator_code;
   } req_type;

   typedef struct packed {
      logic        done_res;
      logic [31:0] answer;
      logic [2:0]  status;
   } rsp_type;

   // 0 reduce, 1 cancel, 2 push
   typedef enum logic [1:0] {
      PR_REDUCE,
      PR_CANCEL,
      PR_PUSH
   } prec_type;

   function automatic prec_type prec_f(input logic [2:0] inc, input logic [2:0] top);
      prec_type r;
      case (inc)
         TK_ADD, TK_SUB: r = (top == TK_OPEN || top == TK_END) ? PR_PUSH : PR_REDUCE;
         TK_MUL, TK_DIV: r = (top == TK_MUL || top == TK_DIV) ? PR_REDUCE : PR_PUSH;
         TK_OPEN:        r = PR_PUSH;
         TK_CLOSE:       r = (top == TK_OPEN) ? PR_CANCEL : PR_REDUCE;
         default:        r = (top == TK_END) ? PR_CANCEL : PR_REDUCE;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/core/infix_two_stack_evaluator_unit.sv
// A number beat is pushed onto the number stack; an operator beat is compared against the
// operator stack top and reduces through the ALU, where a divide reduction uses the
// restoring divider. Throughput: one beat at a time, not ready while busy. Reset:
// synchronous, active high; operator stack holds the end mark, number stack empty.
module infix_two_stack_evaluator_unit
   import itse_pkg::*;
#(
   parameter int OP_STACK_DEPTH  = OP_STACK_DEPTH_DEF,
   parameter int NUM_STACK_DEPTH = NUM_STACK_DEPTH_DEF,
   parameter int FRAC_BITS       = FRAC_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int OAW = $clog2(OP_STACK_DEPTH);
   localparam int NAW = $clog2(NUM_STACK_DEPTH);
   localparam int OCW = $clog2(OP_STACK_DEPTH + 1);
   localparam int NCW = $clog2(NUM_STACK_DEPTH + 1);

   state_type     state_ff, state_in;
   logic [OCW-1:0] ocnt_ff, ocnt_in;
   logic [NCW-1:0] ncnt_ff, ncnt_in;
   logic [2:0]    op_ff, op_in;
   logic [2:0]    top_ff, top_in;
   logic [31:0]   b_ff, b_in;
   logic [31:0]   a_ff, a_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   // operator stack in flops (entry zero is the end mark after clear)
   logic [2:0]    ostk_ff [OP_STACK_DEPTH];
   logic          opush;
   logic [OAW-1:0] opush_addr;
   logic [2:0]    opush_data;

   // number stack in RAM
   logic          nwr;
   logic [NAW-1:0] nwr_addr;
   logic [31:0]   nwr_data;
   logic [NAW-1:0] nrd_addr;
   logic [31:0]   nrd_data;

   logic          alu_start, alu_busy, alu_done;
   logic [31:0]   alu_result;
   prec_type      pr;

   itse_ram #(.WIDTH(32), .DEPTH(NUM_STACK_DEPTH)) u_num (
      .clock   (clock),
      .wr_en   (nwr),
      .wr_addr (nwr_addr),
      .wr_data (nwr_data),
      .rd_addr (nrd_addr),
      .rd_data (nrd_data)
   );

   itse_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
      .clock  (clock),
      .reset  (reset),
      .start  (alu_start),
      .op     (top_ff),
      .a      (a_ff),
      .b      (b_ff),
      .busy   (alu_busy),
      .done   (alu_done),
      .result (alu_result)
   );

   assign pr = prec_f(op_ff, top_ff);

   // sequence one token through the stacks
   always_comb begin
      state_in = state_ff;
      ocnt_in = ocnt_ff;
      ncnt_in = ncnt_ff;
      op_in = op_ff;
      top_in = top_ff;
      b_in = b_ff;
      a_in = a_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      opush = 1'b0;
      opush_addr = ocnt_ff[OAW-1:0];
      opush_data = op_ff;
      nwr = 1'b0;
      nwr_addr = ncnt_ff[NAW-1:0];
      nwr_data = {1'b0, req_data.number_value};
      nrd_addr = '0;
      alu_start = 1'b0;
      req_ready = 1'b0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            req_ready = !rsp_valid_ff;
            if (req_valid && req_ready) begin
               rsp_in = '0;
               op_in = req_data.operator_code;
               if (!req_data.command) begin
                  if (ncnt_ff >= NCW'(NUM_STACK_DEPTH)) begin
                     rsp_in.status = ST_OVERFLOW;
                     ocnt_in = OCW'(1);
                     ncnt_in = '0;
                  end else begin
                     nwr = 1'b1;
                     ncnt_in = ncnt_ff + 1'b1;
                  end
                  state_in = S_OUT;
               end else if (req_data.operator_code == TK_OTHER) begin
                  rsp_in.status = ST_BADOP;
                  state_in = S_FINAL;
               end else begin
                  if (req_data.operator_code == TK_SUB && ncnt_ff == '0) begin
                     nwr = 1'b1;
                     nwr_data = '0;
                     ncnt_in = NCW'(1);
                     state_in = S_TOP;
                  end else if (ncnt_ff == '0 && req_data.operator_code != TK_OPEN) begin
                     rsp_in.status = ST_SYNTAX;
                     state_in = S_FINAL;
                  end else begin
                     state_in = S_TOP;
                  end
               end
            end
         end
         S_TOP: begin
            // loop: compare against stack top
            if (ocnt_ff == '0) begin
               state_in = S_FINAL;
            end else begin
               top_in = ostk_ff[OAW'(ocnt_ff - 1'b1)];
               state_in = S_POPB;
            end
            if (ocnt_ff != '0) begin
               // evaluate on registered top next cycle
               state_in = S_POPA;
            end
         end
         S_POPA: begin
            case (pr)
               PR_PUSH: begin
                  if (ocnt_ff >= OCW'(OP_STACK_DEPTH)) begin
                     rsp_in.status = ST_OVERFLOW;
                  end else begin
                     opush = 1'b1;
                     ocnt_in = ocnt_ff + 1'b1;
                  end
                  state_in = S_FINAL;
               end
               PR_CANCEL: begin
                  ocnt_in = ocnt_ff - 1'b1;
                  state_in = S_FINAL;
               end
               default: begin
                  ocnt_in = ocnt_ff - 1'b1;
                  if (top_ff == TK_OPEN || top_ff == TK_END) begin
                     rsp_in.status = ST_UNPAIR;
                     state_in = S_FINAL;
                  end else if (ncnt_ff < NCW'(2)) begin
                     rsp_in.status = ST_SYNTAX;
                     state_in = S_FINAL;
                  end else begin
                     nrd_addr = NAW'(ncnt_ff - 1'b1);
                     state_in = S_POPB;
                  end
               end
            endcase
         end
         S_POPB: begin
            nrd_addr = NAW'(ncnt_ff - 2'd2);
            b_in = nrd_data;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            a_in = nrd_data;
            ncnt_in = ncnt_ff - 2'd2;
            if (top_ff == TK_DIV && b_ff == '0) begin
               rsp_in.status = ST_DIVZERO;
               state_in = S_FINAL;
            end else begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            alu_start = 1'b1;
            state_in = S_PUSHR;
         end
         S_PUSHR: begin
            if (alu_done) begin
               nwr = 1'b1;
               nwr_data = alu_result;
               ncnt_in = ncnt_ff + 1'b1;
               state_in = S_TOP;
            end
         end
         S_FINAL: begin
            // error clears, empty operator stack gives the answer
            if (rsp_ff.status != ST_OK) begin
               ocnt_in = OCW'(1);
               ncnt_in = '0;
               state_in = S_OUT;
            end else if (ocnt_ff == '0) begin
               if (ncnt_ff != NCW'(1)) begin
                  rsp_in.status = ST_SYNTAX;
                  ocnt_in = OCW'(1);
                  ncnt_in = '0;
                  state_in = S_OUT;
               end else begin
                  nrd_addr = '0;
                  state_in = S_ANS;
               end
            end else begin
               state_in = S_OUT;
            end
         end
         S_ANS: begin
            rsp_in.done_res = 1'b1;
            rsp_in.answer = nrd_data;
            ocnt_in = OCW'(1);
            ncnt_in = '0;
            state_in = S_OUT;
         end
         S_OUT: begin
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ocnt_ff <= OCW'(1);
         ncnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ocnt_ff <= ocnt_in;
         ncnt_ff <= ncnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff <= op_in;
      top_ff <= top_in;
      b_ff <= b_in;
      a_ff <= a_in;
      rsp_ff <= rsp_in;
   end

   // hold the operator stack; entry zero is the end mark always
   always_ff @(posedge clock) begin
      if (reset) begin
         ostk_ff[0] <= TK_END;
      end else if (opush) begin
         ostk_ff[opush_addr] <= opush_data;
      end else if (ocnt_in == OCW'(1) && ocnt_ff != OCW'(1)) begin
         ostk_ff[0] <= TK_END;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_busy: assert property (@(posedge clock) disable iff (reset)
      alu_busy |-> !req_ready) else $error("ready while divider busy");
   a_ocnt: assert property (@(posedge clock) disable iff (reset)
      ocnt_ff <= OCW'(OP_STACK_DEPTH)) else $error("operator count past depth");
   a_ncnt: assert property (@(posedge clock) disable iff (reset)
      ncnt_ff <= NCW'(NUM_STACK_DEPTH)) else $error("number count past depth");
   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> rsp_data.status == ST_OK)
      else $error("done with error status");

endmodule

// File: rtl/core/itse_ram.sv
module itse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write one entry, read registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// File: rtl/core/itse_alu.sv
module itse_alu
   import itse_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [2:0]  op,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic        busy,
   output logic        done,
   output logic [31:0] result
);

   localparam int QW = 32 + FRAC_BITS;
   localparam int CW = $clog2(QW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [31:0]   result_ff, result_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [32:0]   rem_ff, rem_in;
   logic [31:0]   div_ff, div_in;
   logic          neg_ff, neg_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [63:0]   prod_ff, prod_in;
   logic          mul_ff, mul_in;

   logic signed [32:0] sum;
   logic signed [63:0] prod_s;
   logic [63:0]        pmag;
   logic [63:0]        pshift;
   logic [31:0]        amag, bmag;
   logic [32:0]        trial;

   function automatic logic [31:0] sat_mag(input logic [63:0] m, input logic neg);
      logic [31:0] r;
      if (neg) begin
         r = (m >= 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - m[31:0]);
      end else begin
         r = (m >= 64'h8000_0000) ? 32'h7FFF_FFFF : m[31:0];
      end
      return r;
   endfunction

   assign amag = a[31] ? (32'd0 - a) : a;
   assign bmag = b[31] ? (32'd0 - b) : b;
   assign prod_s = $signed(a) * $signed(b);
   assign pmag = prod_ff[63] ? (64'd0 - prod_ff) : prod_ff;
   assign pshift = pmag >> FRAC_BITS;
   assign trial = {rem_ff[31:0], quo_ff[QW-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      result_in = result_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      prod_in = prod_ff;
      mul_in = 1'b0;
      sum = '0;
      if (start) begin
         case (op)
            TK_ADD, TK_SUB: begin
               sum = (op == TK_ADD) ? ($signed({a[31], a}) + $signed({b[31], b}))
                                    : ($signed({a[31], a}) - $signed({b[31], b}));
               result_in = (sum[32] != sum[31]) ? (sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                                : sum[31:0];
               done_in = 1'b1;
            end
            TK_MUL: begin
               prod_in = prod_s;
               mul_in = 1'b1;
               busy_in = 1'b1;
            end
            default: begin
               // restoring divide, one quotient bit per cycle
               quo_in = QW'({amag, {FRAC_BITS{1'b0}}});
               rem_in = '0;
               div_in = bmag;
               neg_in = a[31] ^ b[31];
               cnt_in = CW'(QW);
               busy_in = 1'b1;
            end
         endcase
      end else if (mul_ff) begin
         result_in = sat_mag(pshift, prod_ff[63]);
         busy_in = 1'b0;
         done_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial - {1'b0, div_ff};
            quo_in = {quo_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            result_in = sat_mag(64'(quo_in), neg_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         mul_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         mul_ff <= mul_in;
      end
      result_ff <= result_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      prod_ff <= prod_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign result = result_ff;

endmodule

// File: test/tb_top.sv
module tb_top;
   import itse_pkg::*;

   localparam int OP_DEPTH  = OP_STACK_DEPTH_DEF;
   localparam int NUM_DEPTH = NUM_STACK_DEPTH_DEF;
   localparam int FRAC      = FRAC_BITS_DEF;
   localparam int RAND_ITEMS = 900;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   infix_two_stack_evaluator_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // evaluator mirror: its own operator and operand stacks
   tok_type         ops[OP_DEPTH];
   int              op_cnt;
   logic signed [31:0] nums[NUM_DEPTH];
   int              num_cnt;

   rsp_type         answer_q[$];
   rsp_type         typed_answer[int];
   req_type         token_q[$];
   int              accepted_beats;
   int              errors;

   function automatic void clear_eval();
      ops[0]  = TK_END;
      op_cnt  = 1;
      num_cnt = 0;
   endfunction

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] apply_sign(longint unsigned m, bit neg);
      longint v;
      if (m > 64'h7FFFFFFFFFFFFFFF) m = 64'h7FFFFFFFFFFFFFFF;
      v = m;
      return clamp32(neg ? -v : v);
   endfunction

   function automatic longint unsigned abs64(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic status_type reduce_top(tok_type op);
      longint a, b, p;
      logic signed [31:0] r;
      if (op == TK_OPEN || op == TK_END) return ST_UNPAIR;
      if (num_cnt < 2) return ST_SYNTAX;
      b = nums[num_cnt-1];
      a = nums[num_cnt-2];
      num_cnt -= 2;
      case (op)
         TK_ADD: r = clamp32(a + b);
         TK_SUB: r = clamp32(a - b);
         TK_MUL: begin
            p = a * b;
            r = apply_sign(abs64(p) >> FRAC, p < 0);
         end
         TK_DIV: begin
            if (b == 0) return ST_DIVZERO;
            r = apply_sign((abs64(a) << FRAC) / abs64(b), (a < 0) != (b < 0));
         end
         default: return ST_BADOP;
      endcase
      nums[num_cnt] = r;
      num_cnt++;
      return ST_OK;
   endfunction

   function automatic status_type apply_operator(tok_type op, ref rsp_type res);
      prec_type c;
      status_type st;
      c = PR_PUSH;
      if (op == TK_OTHER) return ST_BADOP;
      // leading minus gets an implicit zero operand
      if (op == TK_SUB && num_cnt == 0) begin
         nums[0] = 0;
         num_cnt = 1;
      end
      if (num_cnt == 0 && op != TK_OPEN) return ST_SYNTAX;
      while (op_cnt > 0) begin
         tok_type top;
         top = ops[op_cnt-1];
         case (op)
            TK_ADD, TK_SUB: c = (top == TK_OPEN || top == TK_END) ? PR_PUSH : PR_REDUCE;
            TK_MUL, TK_DIV: c = (top == TK_MUL || top == TK_DIV) ? PR_REDUCE : PR_PUSH;
            TK_OPEN:        c = PR_PUSH;
            TK_CLOSE:       c = (top == TK_OPEN) ? PR_CANCEL : PR_REDUCE;
            default:        c = (top == TK_END) ? PR_CANCEL : PR_REDUCE;
         endcase
         if (c != PR_REDUCE) break;
         op_cnt--;
         st = reduce_top(top);
         if (st != ST_OK) return st;
      end
      if (c != PR_CANCEL) begin
         if (op_cnt >= OP_DEPTH) return ST_OVERFLOW;
         ops[op_cnt] = op;
         op_cnt++;
      end else begin
         op_cnt--;
      end
      if (op_cnt == 0) begin
         if (num_cnt != 1) return ST_SYNTAX;
         res.answer   = nums[0];
         res.done_res = 1'b1;
         clear_eval();
      end
      return ST_OK;
   endfunction

   function automatic rsp_type eval_token(req_type t);
      rsp_type res;
      status_type st;
      res = '0;
      st  = ST_OK;
      if (t.command == 1'b0) begin
         if (num_cnt >= NUM_DEPTH) st = ST_OVERFLOW;
         else begin
            nums[num_cnt] = {1'b0, t.number_value};
            num_cnt++;
         end
      end else begin
         st = apply_operator(tok_type'(t.operator_code), res);
      end
      if (st != ST_OK) begin
         clear_eval();
         res = '0;
      end
      res.status = st;
      return res;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch %s at beat %0d: got %0h expected %0h", field, accepted_beats,
               got, want);
      errors++;
   endtask

   // predict on accepted request beats, check accepted response beats
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (answer_q.size() == 0) begin
               report_mismatch("extra response beat", 1, 0);
            end else begin
               rsp_type want;
               want = answer_q.pop_front();
               if (rsp_data.done_res !== want.done_res)
                  report_mismatch("done_res", rsp_data.done_res, want.done_res);
               if (rsp_data.answer !== want.answer)
                  report_mismatch("answer", rsp_data.answer, want.answer);
               if (rsp_data.status !== want.status)
                  report_mismatch("status", rsp_data.status, want.status);
            end
         end
         if (req_valid && req_ready) begin
            rsp_type pred;
            pred = eval_token(req_data);
            if (typed_answer.exists(accepted_beats)) pred = typed_answer[accepted_beats];
            answer_q = {answer_q, pred};
            accepted_beats++;
         end
      end
   end

   function automatic req_type num_tok(logic [30:0] v);
      req_type t;
      t = '0;
      t.number_value = v;
      return t;
   endfunction

   function automatic req_type op_tok(tok_type c);
      req_type t;
      t = '0;
      t.command = 1'b1;
      t.operator_code = c;
      return t;
   endfunction

   function automatic rsp_type mk_rsp(bit d, logic [31:0] a, status_type s);
      rsp_type r;
      r.done_res = d;
      r.answer   = a;
      r.status   = s;
      return r;
   endfunction

   // append one token to the send queue
   function automatic void queue_tok(req_type t);
      token_q = {token_q, t};
   endfunction

   function automatic logic [30:0] rand_value();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 31'h7FFFFFFF;
         2, 3:    return 31'($urandom());
         4:       return 31'($urandom_range(0, 65535));
         default: return 31'(($urandom_range(0, 9) << FRAC) |
                             ($urandom_range(0, 65535) & 16'hC000));
      endcase
   endfunction

   // well-formed expression tokens with random content
   function automatic void gen_expr(int depth);
      int terms;
      if ($urandom_range(0, 7) == 0) queue_tok(op_tok(TK_SUB));
      terms = $urandom_range(1, 4);
      for (int i = 0; i < terms; i++) begin
         if (i > 0) queue_tok(op_tok(tok_type'($urandom_range(0, 3))));
         if (depth < 3 && $urandom_range(0, 3) == 0) begin
            queue_tok(op_tok(TK_OPEN));
            gen_expr(depth + 1);
            queue_tok(op_tok(TK_CLOSE));
         end else begin
            queue_tok(num_tok(rand_value()));
         end
      end
   endfunction

   task automatic send_token(req_type t, ref int burst_left);
      // start a new burst after a random gap
      if (burst_left == 0) begin
         int gap;
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
      burst_left--;
   endtask

   // receiver stall pattern, choosing a new random mode at regular intervals
   initial begin
      int cyc;
      int mode;
      cyc = 0;
      mode = 0;
      @(negedge clock);
      forever begin
         if (cyc % 256 == 0) mode = $urandom_range(0, 3);
         case (mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 1) == 1);
            2:       rsp_ready <= (cyc % 7 < 4);
            default: rsp_ready <= ($urandom_range(0, 9) == 0);
         endcase
         cyc++;
         @(negedge clock);
      end
   end

   initial begin
      req_type    rows[$];
      int         burst_left;
      int         t0;
      accepted_beats = 0;
      errors = 0;
      burst_left = 0;
      clear_eval();

      // directed rows; some with the answer typed in
      rows = {rows, op_tok(TK_ADD)};   typed_answer[0] = mk_rsp(0, 0, ST_SYNTAX);
      rows = {rows, op_tok(TK_OTHER)}; typed_answer[1] = mk_rsp(0, 0, ST_BADOP);
      rows = {rows, num_tok(31'h7FFFFFFF)}; typed_answer[2] = mk_rsp(0, 0, ST_OK);
      rows = {rows, num_tok(31'h7FFFFFFF)}; typed_answer[3] = mk_rsp(0, 0, ST_OK);
      rows = {rows, op_tok(TK_ADD)};   typed_answer[4] = mk_rsp(0, 0, ST_OK);
      rows = {rows, op_tok(TK_END)};   typed_answer[5] = mk_rsp(1, 32'h7FFFFFFF, ST_OK);
      rows = {rows, op_tok(TK_SUB)};
      rows = {rows, num_tok(31'h10000)};
      rows = {rows, op_tok(TK_END)};   typed_answer[8] = mk_rsp(1, 32'hFFFF0000, ST_OK);
      rows = {rows, num_tok(31'h50000)};
      rows = {rows, op_tok(TK_DIV)};
      rows = {rows, num_tok(31'h0)};
      rows = {rows, op_tok(TK_END)};   typed_answer[12] = mk_rsp(0, 0, ST_DIVZERO);
      rows = {rows, num_tok(31'h1)};
      rows = {rows, op_tok(TK_CLOSE)}; typed_answer[14] = mk_rsp(0, 0, ST_UNPAIR);
      rows = {rows, op_tok(TK_OPEN)};
      rows = {rows, num_tok(31'h2)};
      rows = {rows, op_tok(TK_END)};   typed_answer[17] = mk_rsp(0, 0, ST_UNPAIR);
      rows = {rows, num_tok(31'h3)};
      rows = {rows, num_tok(31'h4)};
      rows = {rows, op_tok(TK_END)};   typed_answer[20] = mk_rsp(0, 0, ST_SYNTAX);
      rows = {rows, num_tok(31'h20000)};
      rows = {rows, op_tok(TK_MUL)};
      rows = {rows, num_tok(31'h30000)};
      rows = {rows, op_tok(TK_END)};

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) send_token(rows[i], burst_left);

      // random phase: mostly valid expressions, some noise and overflow runs
      t0 = accepted_beats;
      while (accepted_beats - t0 < RAND_ITEMS) begin
         case ($urandom_range(0, 19))
            0: queue_tok(req_type'({$urandom(), 3'($urandom_range(0, 7))}));
            1: repeat (NUM_DEPTH + 1) queue_tok(num_tok(rand_value()));
            2: begin
               repeat (OP_DEPTH) queue_tok(op_tok(TK_OPEN));
               queue_tok(op_tok(TK_END));
            end
            3: begin
               gen_expr(0);
               void'(token_q.pop_back());
               queue_tok(op_tok(tok_type'($urandom_range(0, 7))));
            end
            default: begin
               gen_expr(0);
               queue_tok(op_tok(TK_END));
            end
         endcase
         while (token_q.size() > 0) send_token(token_q.pop_front(), burst_left);
      end
      req_valid <= 1'b0;

      // drain
      while (answer_q.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/itse_pkg.sv
rtl/core/itse_ram.sv
rtl/core/itse_alu.sv
rtl/core/infix_two_stack_evaluator_unit.sv
test/tb_top.sv
